### rtl/dmtt_pkg.sv
// ----------------------------------------------------------------------------
// dmtt_pkg
// Shared types and codes for the direct-mapped transposition table.
// ----------------------------------------------------------------------------
`default_nettype none

package dmtt_pkg;

  localparam logic [1:0] CMD_PROBE  = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] BOUND_NONE  = 2'd0;
  localparam logic [1:0] BOUND_EXACT = 2'd1;
  localparam logic [1:0] BOUND_UPPER = 2'd2;
  localparam logic [1:0] BOUND_LOWER = 2'd3;

  localparam logic [15:0] MATE_THRESHOLD_RESET = 16'd49000;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [63:0]        key;
    logic [1:0]         flag;
    logic signed [16:0] score;
    logic [6:0]         depth;
    logic [23:0]        move;
  } entry_t;

  typedef struct packed {
    logic clear_write;
    logic capture;
    logic commit;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

### rtl/dmtt_ctrl.sv
// ----------------------------------------------------------------------------
// dmtt_ctrl
// Sequencer for the table: clearing pass, accept, lookup/commit, and output.
// ----------------------------------------------------------------------------
`default_nettype none

module dmtt_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output dmtt_pkg::ctrl_cmd_t        cmd,
  input  wire dmtt_pkg::ctrl_status_t status
);

  dmtt_pkg::state_t state;
  dmtt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmtt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dmtt_pkg::ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = dmtt_pkg::ST_IDLE;
        end
      end
      dmtt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = dmtt_pkg::ST_LOOKUP;
        end
      end
      dmtt_pkg::ST_LOOKUP: begin
        if (status.out_free) begin
          state_next = dmtt_pkg::ST_IDLE;
        end else begin
          state_next = dmtt_pkg::ST_HOLD;
        end
      end
      dmtt_pkg::ST_HOLD: begin
        if (status.out_free) begin
          state_next = dmtt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dmtt_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      dmtt_pkg::ST_CLEAR: begin
        cmd.clear_write = 1'b1;
      end
      dmtt_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      dmtt_pkg::ST_LOOKUP: begin
        cmd.commit   = 1'b1;
        cmd.load_out = status.out_free;
      end
      dmtt_pkg::ST_HOLD: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == dmtt_pkg::ST_LOOKUP))
    else $error("accepted beat did not move to lookup");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("output loaded while occupied");

  a_hold_origin: assert property (@(posedge clk) disable iff (rst)
    (state == dmtt_pkg::ST_HOLD) |->
      ($past(state) == dmtt_pkg::ST_LOOKUP || $past(state) == dmtt_pkg::ST_HOLD))
    else $error("hold state entered from an unexpected state");

endmodule

`default_nettype wire

### rtl/dmtt_datapath.sv
// ----------------------------------------------------------------------------
// dmtt_datapath
// Entry memory, captured request, score adjustment, and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmtt_datapath #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dmtt_pkg::ctrl_cmd_t  cmd,
  output dmtt_pkg::ctrl_status_t    status,
  input  wire logic                 cfg_we,
  input  wire logic [15:0]          cfg_wdata,
  input  wire logic [1:0]           command,
  input  wire logic [63:0]          position_key,
  input  wire logic [6:0]           search_depth,
  input  wire logic [7:0]           ply_from_root,
  input  wire logic signed [16:0]   alpha_bound,
  input  wire logic signed [16:0]   beta_bound,
  input  wire logic signed [16:0]   entry_score,
  input  wire logic [1:0]           bound_kind,
  input  wire logic [23:0]          move_code,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      key_matched,
  output logic [23:0]               best_move,
  output logic                      score_valid,
  output logic signed [16:0]        probe_score
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  function automatic logic signed [16:0] mate_shift(
    input logic signed [16:0] s,
    input logic [7:0]         ply,
    input logic [15:0]        thr,
    input logic               away
  );
    logic signed [17:0] se;
    logic signed [17:0] te;
    logic signed [17:0] pe;
    logic signed [17:0] sum;
    logic signed [16:0] res;
    se = $signed({s[16], s});
    te = $signed({2'b00, thr});
    pe = $signed({10'd0, ply});
    if (se > te) begin
      sum = away ? (se + pe) : (se - pe);
    end else if (se < -te) begin
      sum = away ? (se - pe) : (se + pe);
    end else begin
      sum = se;
    end
    if (sum[17] == 1'b0 && sum[16] == 1'b1) begin
      res = 17'sd65535;
    end else if (sum[17] == 1'b1 && sum[16] == 1'b0) begin
      res = -17'sd65536;
    end else begin
      res = sum[16:0];
    end
    return res;
  endfunction

  dmtt_pkg::entry_t mem [TABLE_ENTRIES];

  logic [15:0]        mate_threshold;
  logic [IDX_W-1:0]   clr_addr;
  logic [IDX_W-1:0]   idx_q;
  dmtt_pkg::entry_t   rd;
  logic [1:0]         command_q;
  logic [63:0]        key_q;
  logic [6:0]         depth_q;
  logic [7:0]         ply_q;
  logic signed [16:0] alpha_q;
  logic signed [16:0] beta_q;
  logic signed [16:0] score_q;
  logic [1:0]         kind_q;
  logic [23:0]        move_q;

  logic               match;
  logic               depth_ok;
  logic signed [16:0] stored_adj;
  logic signed [16:0] add_adj;
  logic               res_matched;
  logic [23:0]        res_move;
  logic               res_valid;
  logic signed [16:0] res_score;
  logic               replace;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  dmtt_pkg::entry_t   mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      mate_threshold <= dmtt_pkg::MATE_THRESHOLD_RESET;
    end else if (cfg_we) begin
      mate_threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_write) begin
      clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  assign status.clear_last = (clr_addr == IDX_W'(TABLE_ENTRIES - 1));
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      command_q <= command;
      key_q     <= position_key;
      depth_q   <= search_depth;
      ply_q     <= ply_from_root;
      alpha_q   <= alpha_bound;
      beta_q    <= beta_bound;
      score_q   <= entry_score;
      kind_q    <= bound_kind;
      move_q    <= move_code;
      idx_q     <= position_key[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.capture) begin
      rd <= mem[position_key[IDX_W-1:0]];
    end
  end

  assign match      = (rd.key == key_q);
  assign depth_ok   = (rd.depth >= depth_q);
  assign stored_adj = mate_shift(rd.score, ply_q, mate_threshold, 1'b0);
  assign add_adj    = mate_shift(score_q, ply_q, mate_threshold, 1'b1);
  assign replace    = (rd.key == 64'd0) || match || (rd.depth < depth_q);

  always_comb begin
    res_matched = 1'b0;
    res_move    = '0;
    res_valid   = 1'b0;
    res_score   = '0;
    if (command_q == dmtt_pkg::CMD_PROBE && match) begin
      res_matched = 1'b1;
      res_move    = rd.move;
      if (depth_ok) begin
        unique case (rd.flag)
          dmtt_pkg::BOUND_EXACT: begin
            res_valid = 1'b1;
            res_score = stored_adj;
          end
          dmtt_pkg::BOUND_UPPER: begin
            if (stored_adj <= alpha_q) begin
              res_valid = 1'b1;
              res_score = alpha_q;
            end
          end
          dmtt_pkg::BOUND_LOWER: begin
            if (stored_adj >= beta_q) begin
              res_valid = 1'b1;
              res_score = beta_q;
            end
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = '0;
    if (cmd.clear_write) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
    end else if (cmd.commit) begin
      case (command_q)
        dmtt_pkg::CMD_ADD: begin
          mem_we          = replace;
          mem_wdata.key   = key_q;
          mem_wdata.flag  = kind_q;
          mem_wdata.score = add_adj;
          mem_wdata.depth = depth_q;
          mem_wdata.move  = move_q;
        end
        dmtt_pkg::CMD_REMOVE: begin
          mem_we = 1'b1;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      key_matched <= res_matched;
      best_move   <= res_move;
      score_valid <= res_valid;
      probe_score <= res_score;
    end
  end

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_write, cmd.capture, cmd.commit}))
    else $error("memory commands overlap");

  a_miss_is_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !key_matched) |->
      (best_move == 24'd0 && !score_valid && probe_score == 17'sd0))
    else $error("unmatched result carries data");

  a_clear_advance: assert property (@(posedge clk) disable iff (rst)
    (!rst && cmd.clear_write && !status.clear_last) |=>
      (clr_addr == $past(clr_addr) + IDX_W'(1)))
    else $error("clearing pass skipped an entry");

endmodule

`default_nettype wire

### rtl/direct_mapped_transposition_table_top.sv
// ----------------------------------------------------------------------------
// direct_mapped_transposition_table_top
// Direct-mapped search cache with probe, add and remove commands.
// ----------------------------------------------------------------------------
//   Channel   Handshake             Payload
//   request   in_valid/in_ready     command, position_key, search_depth,
//                                   ply_from_root, alpha_bound, beta_bound,
//                                   entry_score, bound_kind, move_code
//   result    out_valid/out_ready   key_matched, best_move, score_valid,
//                                   probe_score
//   config    cfg_we                cfg_wdata (mate threshold)
//
// Each beat reads the entry memory when accepted; the lookup state checks the
// entry, writes it back and loads the result register once the output is free.
// After reset a clearing pass writes TABLE_ENTRIES entries, one per cycle,
// before in_ready rises.
// A result held by out_ready low still lets the next beat in; that beat then
// waits in the hold state, with in_ready low, until the result is taken.
// TABLE_ENTRIES must be a power of two; the slot is the low key bits.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_transposition_table_top #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         command,
  input  wire logic [63:0]        position_key,
  input  wire logic [6:0]         search_depth,
  input  wire logic [7:0]         ply_from_root,
  input  wire logic signed [16:0] alpha_bound,
  input  wire logic signed [16:0] beta_bound,
  input  wire logic signed [16:0] entry_score,
  input  wire logic [1:0]         bound_kind,
  input  wire logic [23:0]        move_code,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    key_matched,
  output logic [23:0]             best_move,
  output logic                    score_valid,
  output logic signed [16:0]      probe_score
);

  dmtt_pkg::ctrl_cmd_t    cmd;
  dmtt_pkg::ctrl_status_t status;

  dmtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  dmtt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .command       (command),
    .position_key  (position_key),
    .search_depth  (search_depth),
    .ply_from_root (ply_from_root),
    .alpha_bound   (alpha_bound),
    .beta_bound    (beta_bound),
    .entry_score   (entry_score),
    .bound_kind    (bound_kind),
    .move_code     (move_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .key_matched   (key_matched),
    .best_move     (best_move),
    .score_valid   (score_valid),
    .probe_score   (probe_score)
  );

endmodule

`default_nettype wire
